// File: rtl/slot_claim_negotiator_macros.svh
`ifndef SLOT_CLAIM_NEGOTIATOR_MACROS_SVH
`define SLOT_CLAIM_NEGOTIATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scn_pkg.sv
`timescale 1ns / 1ps

package scn_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int SLOT_W     = 6;
  localparam int WANT_DEPTH = 8;
  localparam int WIDX_W     = 3;
  localparam int WCNT_W     = 4;
  localparam int AGE_W      = 5;
  localparam int MSG_DEPTH  = 10;
  localparam int MIDX_W     = 4;
  localparam int CNT_W      = 7;

  localparam logic [AGE_W-1:0] AGE_MAX = 5'd31;
  localparam logic [7:0] NO_CLAIM = 8'hFF;
  localparam logic [3:0] TIMEOUT_RST = 4'd10;

  localparam logic [2:0] ACT_CLAIM = 3'd0;
  localparam logic [2:0] ACT_HB    = 3'd1;
  localparam logic [2:0] ACT_REJ   = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_START = 3'd4;

  localparam logic [1:0] KIND_CLAIM = 2'd0;
  localparam logic [1:0] KIND_HB    = 2'd1;
  localparam logic [1:0] KIND_REJ   = 2'd2;

  localparam logic REG_MY_ID   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] slot;
    logic [7:0] addr;
  } msg_t;

endpackage

// File: rtl/scn_age_ram.sv
`timescale 1ns / 1ps

module scn_age_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [scn_pkg::SLOT_W-1:0]   waddr_i,
  input  logic [scn_pkg::AGE_W-1:0]    wdata_i,
  input  logic [scn_pkg::SLOT_W-1:0]   raddr_i,
  output logic [scn_pkg::AGE_W-1:0]    rdata_o
);

  logic [scn_pkg::AGE_W-1:0] mem [scn_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/slot_claim_negotiator.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | action, sender_id, slot, addressee
// out     | output    | out_valid_o/out_stall_i | send_*, own_slot, slot0_owner, ...
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
// Tick: an age walk over all slots through the age RAM (one read and one write
// port), then a heartbeat per wanted entry, then, with one entry left, a backward vacancy scan.
// Start and emptied wanted list: a forward vacancy scan.
// Every message ends at the output, one result per cycle while out_stall_i is low.
// Reset clears the valid bits at once; no clearing pass. in_stall_o is high
// from accept until the last result transfers.

module slot_claim_negotiator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [7:0] sender_id_i,
  input  logic [5:0] slot_i,
  input  logic [7:0] addressee_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       send_valid_o,
  output logic [1:0] send_kind_o,
  output logic [6:0] send_slot_o,
  output logic [7:0] send_addressee_o,
  output logic [5:0] own_slot_o,
  output logic [7:0] slot0_owner_o,
  output logic       status_valid_o,
  output logic       last_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EXEC     = 10'b0000000010,
    S_TBL_RD   = 10'b0000000100,
    S_TBL_WR   = 10'b0000001000,
    S_WANT_HB  = 10'b0000010000,
    S_VAC_BACK = 10'b0000100000,
    S_VAC_FWD  = 10'b0001000000,
    S_REM      = 10'b0010000000,
    S_REJ_SCAN = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] my_id_q;
  logic [3:0] limit_q;
  logic [2:0] act_q, act_d;
  logic [7:0] sender_q, sender_d;
  logic [5:0] slot_q, slot_d;
  logic [7:0] addr_q, addr_d;
  logic [scn_pkg::NUM_SLOTS-1:0] valid_q, valid_d;
  logic [7:0] node0_q, node0_d;
  logic [5:0] want_slot_q [scn_pkg::WANT_DEPTH];
  logic [5:0] want_slot_d [scn_pkg::WANT_DEPTH];
  logic [scn_pkg::AGE_W-1:0] want_age_q [scn_pkg::WANT_DEPTH];
  logic [scn_pkg::AGE_W-1:0] want_age_d [scn_pkg::WANT_DEPTH];
  logic [scn_pkg::WCNT_W-1:0] count_q, count_d;
  logic [7:0] claim_q, claim_d;
  logic heard_q, heard_d;
  scn_pkg::msg_t msg_q [scn_pkg::MSG_DEPTH];
  scn_pkg::msg_t msg_d [scn_pkg::MSG_DEPTH];
  logic [scn_pkg::MIDX_W-1:0] msg_n_q, msg_n_d;
  logic [scn_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic first_q, first_d;

  logic ram_we;
  logic [5:0] ram_waddr, ram_raddr;
  logic [scn_pkg::AGE_W-1:0] ram_wdata, ram_rdata;

  logic push_en;
  scn_pkg::msg_t push_msg;
  logic [scn_pkg::AGE_W-1:0] nage;
  logic [scn_pkg::WIDX_W-1:0] widx;
  logic [scn_pkg::MIDX_W-1:0] last_idx;
  logic rm_en;
  logic [scn_pkg::WIDX_W-1:0] rm_idx;

  scn_age_ram u_age_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign widx = cnt_q[scn_pkg::WIDX_W-1:0];
  assign last_idx = (msg_n_q == '0) ? '0 : msg_n_q - 1'b1;

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    sender_d  = sender_q;
    slot_d    = slot_q;
    addr_d    = addr_q;
    valid_d   = valid_q;
    node0_d   = node0_q;
    want_slot_d = want_slot_q;
    want_age_d  = want_age_q;
    count_d   = count_q;
    claim_d   = claim_q;
    heard_d   = heard_q;
    msg_d     = msg_q;
    msg_n_d   = msg_n_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    ram_raddr = cnt_q[5:0];
    push_en   = 1'b0;
    push_msg  = '0;
    nage      = '0;
    rm_en     = 1'b0;
    rm_idx    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          sender_d = sender_id_i;
          slot_d   = slot_i;
          addr_d   = addressee_i;
          msg_n_d  = '0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q)
          scn_pkg::ACT_CLAIM: begin
            if (sender_q == my_id_q && !heard_q && claim_q == {2'b00, slot_q}) begin
              for (int j = 1; j < scn_pkg::WANT_DEPTH; j++) begin
                want_slot_d[j] = want_slot_q[j-1];
                want_age_d[j]  = want_age_q[j-1];
              end
              want_slot_d[0] = slot_q;
              want_age_d[0]  = '0;
              count_d = (count_q < scn_pkg::WCNT_W'(scn_pkg::WANT_DEPTH)) ?
                        count_q + 1'b1 : scn_pkg::WCNT_W'(scn_pkg::WANT_DEPTH);
              valid_d[slot_q] = 1'b1;
              if (slot_q == '0) node0_d = sender_q;
              ram_we = 1'b1;
            end
            heard_d = 1'b1;
            cnt_d   = '0;
            state_d = S_REJ_SCAN;
          end
          scn_pkg::ACT_HB: begin
            valid_d[slot_q] = 1'b1;
            if (slot_q == '0) node0_d = sender_q;
            ram_we  = 1'b1;
            state_d = S_EMIT;
          end
          scn_pkg::ACT_REJ: begin
            valid_d[slot_q] = 1'b1;
            if (slot_q == '0) node0_d = sender_q;
            ram_we = 1'b1;
            cnt_d  = '0;
            state_d = (sender_q != my_id_q && addr_q == my_id_q) ? S_REM : S_EMIT;
          end
          scn_pkg::ACT_TICK: begin
            cnt_d   = '0;
            state_d = S_TBL_RD;
          end
          scn_pkg::ACT_START: begin
            cnt_d   = '0;
            state_d = S_VAC_FWD;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_TBL_RD: begin
        state_d = S_TBL_WR;
      end
      S_TBL_WR: begin
        ram_raddr = cnt_q[5:0] + 6'd1;
        nage = (ram_rdata == scn_pkg::AGE_MAX) ? ram_rdata : ram_rdata + 1'b1;
        if (valid_q[cnt_q[5:0]]) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[5:0];
          ram_wdata = nage;
          if (nage > {1'b0, limit_q}) valid_d[cnt_q[5:0]] = 1'b0;
        end
        if (cnt_q[5:0] == 6'd63) begin
          if (count_q != '0) begin
            cnt_d   = scn_pkg::CNT_W'(count_q - 1'b1);
            state_d = S_WANT_HB;
          end else begin
            state_d = S_EMIT;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WANT_HB: begin
        push_en  = 1'b1;
        push_msg = '{kind: scn_pkg::KIND_HB, slot: {1'b0, want_slot_q[widx]}, addr: 8'd0};
        if (widx != '0) begin
          nage = (want_age_q[widx] == scn_pkg::AGE_MAX) ? want_age_q[widx] :
                 want_age_q[widx] + 1'b1;
          want_age_d[widx] = nage;
          if (nage > {1'b0, limit_q}) begin
            rm_en  = 1'b1;
            rm_idx = widx;
          end
          cnt_d = cnt_q - 1'b1;
        end else if (count_q == scn_pkg::WCNT_W'(1)) begin
          if (want_slot_q[0] == '0) begin
            claim_d = scn_pkg::NO_CLAIM;
            state_d = S_EMIT;
          end else begin
            cnt_d   = {1'b0, want_slot_q[0] - 6'd1};
            first_d = 1'b1;
            state_d = S_VAC_BACK;
          end
        end else begin
          state_d = S_EMIT;
        end
      end
      S_VAC_BACK: begin
        first_d = 1'b0;
        if (valid_q[cnt_q[5:0]]) begin
          state_d = S_EMIT;
          if (first_q || claim_q == {2'b00, cnt_q[5:0]}) begin
            claim_d = scn_pkg::NO_CLAIM;
          end else begin
            claim_d  = {2'b00, cnt_q[5:0]} + 8'd1;
            push_en  = 1'b1;
            push_msg = '{kind: scn_pkg::KIND_CLAIM, slot: {1'b0, cnt_q[5:0]} + 7'd1,
                         addr: 8'd0};
            heard_d  = 1'b0;
          end
        end else if (cnt_q[5:0] == '0) begin
          claim_d  = 8'd0;
          push_en  = 1'b1;
          push_msg = '{kind: scn_pkg::KIND_CLAIM, slot: 7'd0, addr: 8'd0};
          heard_d  = 1'b0;
          state_d  = S_EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_VAC_FWD: begin
        if (cnt_q == scn_pkg::CNT_W'(scn_pkg::NUM_SLOTS) || !valid_q[cnt_q[5:0]]) begin
          claim_d  = {1'b0, cnt_q};
          push_en  = 1'b1;
          push_msg = '{kind: scn_pkg::KIND_CLAIM, slot: cnt_q, addr: 8'd0};
          heard_d  = 1'b0;
          state_d  = S_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_REM: begin
        if (cnt_q[scn_pkg::WCNT_W-1:0] < count_q) begin
          if (want_slot_q[widx] == slot_q) begin
            rm_en  = 1'b1;
            rm_idx = widx;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else if (count_q == '0) begin
          cnt_d   = '0;
          state_d = S_VAC_FWD;
        end else begin
          if (count_q == scn_pkg::WCNT_W'(1)) begin
            ram_we    = 1'b1;
            ram_waddr = want_slot_q[0];
          end
          if (want_age_q[0] != scn_pkg::AGE_MAX) want_age_d[0] = want_age_q[0] + 1'b1;
          state_d = S_EMIT;
        end
      end
      S_REJ_SCAN: begin
        if (cnt_q[scn_pkg::WCNT_W-1:0] < count_q) begin
          if (want_slot_q[widx] == slot_q && sender_q != my_id_q) begin
            push_en  = 1'b1;
            push_msg = '{kind: scn_pkg::KIND_REJ, slot: {1'b0, slot_q}, addr: sender_q};
          end
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (cnt_q[scn_pkg::MIDX_W-1:0] == last_idx) begin
            msg_n_d = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (rm_en) begin
      for (int j = 0; j < scn_pkg::WANT_DEPTH - 1; j++) begin
        if (j >= int'(rm_idx)) begin
          want_slot_d[j] = want_slot_q[j+1];
          want_age_d[j]  = want_age_q[j+1];
        end
      end
      count_d = count_q - 1'b1;
    end

    if (push_en && msg_n_q < scn_pkg::MIDX_W'(scn_pkg::MSG_DEPTH)) begin
      msg_d[msg_n_q] = push_msg;
      msg_n_d = msg_n_q + 1'b1;
    end

    if (state_d == S_EMIT && state_q != S_EMIT) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      my_id_q <= '0;
      limit_q <= scn_pkg::TIMEOUT_RST;
      valid_q <= '0;
      node0_q <= '0;
      count_q <= '0;
      claim_q <= scn_pkg::NO_CLAIM;
      heard_q <= 1'b0;
      msg_n_q <= '0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      node0_q <= node0_d;
      count_q <= count_d;
      claim_q <= claim_d;
      heard_q <= heard_d;
      msg_n_q <= msg_n_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          scn_pkg::REG_MY_ID:   my_id_q <= cfg_data_i;
          scn_pkg::REG_TIMEOUT: limit_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    sender_q    <= sender_d;
    slot_q      <= slot_d;
    addr_q      <= addr_d;
    want_slot_q <= want_slot_d;
    want_age_q  <= want_age_d;
    msg_q       <= msg_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_EMIT);
  assign send_valid_o     = (msg_n_q != '0);
  assign send_kind_o      = send_valid_o ? msg_q[cnt_q[scn_pkg::MIDX_W-1:0]].kind : 2'd0;
  assign send_slot_o      = send_valid_o ? msg_q[cnt_q[scn_pkg::MIDX_W-1:0]].slot : 7'd0;
  assign send_addressee_o = send_valid_o ? msg_q[cnt_q[scn_pkg::MIDX_W-1:0]].addr : 8'd0;
  assign own_slot_o       = (count_q != '0) ? want_slot_q[0] : 6'd0;
  assign slot0_owner_o    = valid_q[0] ? node0_q : 8'd0;
  assign status_valid_o   = (count_q != '0) && valid_q[0];
  assign last_o           = (cnt_q[scn_pkg::MIDX_W-1:0] == last_idx);

endmodule

// File: rtl/scn_checker.sv
`timescale 1ns / 1ps
`include "slot_claim_negotiator_macros.svh"

module scn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       send_valid_o,
  input logic [6:0] send_slot_o,
  input logic       last_o
);

  `SCN_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by busy")
  `SCN_ASSERT_NOW(a_no_accept_while_out, out_valid_o, in_stall_o, "input open while results pending")
  `SCN_ASSERT_NOW(a_empty_is_last, out_valid_o && !send_valid_o, last_o, "empty result not last")
  `SCN_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(send_slot_o), "stalled result changed")

endmodule

bind slot_claim_negotiator scn_checker u_scn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .send_valid_o (send_valid_o),
  .send_slot_o  (send_slot_o),
  .last_o       (last_o)
);

// File: verif/slot_claim_negotiator_tb.sv
`timescale 1ns / 1ps

module slot_claim_negotiator_tb;

  typedef struct packed {
    logic       sv;
    logic [1:0] kind;
    logic [6:0] slot;
    logic [7:0] addr;
    logic [5:0] own;
    logic [7:0] lead;
    logic       st;
    logic       lst;
  } status_msg_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i = '0;
  logic [7:0] sender_id_i = '0;
  logic [5:0] slot_i = '0;
  logic [7:0] addressee_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       send_valid_o;
  logic [1:0] send_kind_o;
  logic [6:0] send_slot_o;
  logic [7:0] send_addressee_o;
  logic [5:0] own_slot_o;
  logic [7:0] slot0_owner_o;
  logic       status_valid_o;
  logic       last_o;

  slot_claim_negotiator u_dut (.*);

  // negotiator shadow state
  logic [7:0] node_id;
  logic [3:0] expiry;
  bit         slot_taken [scn_pkg::NUM_SLOTS];
  logic [7:0] slot_node [scn_pkg::NUM_SLOTS];
  int         slot_age [scn_pkg::NUM_SLOTS];
  int         tbl_len;
  int         want_slot [scn_pkg::WANT_DEPTH];
  int         want_age [scn_pkg::WANT_DEPTH];
  int         want_cnt;
  int         pend_claim;
  bit         claim_echoed;
  logic [1:0] msg_kind [scn_pkg::MSG_DEPTH];
  int         msg_slot [scn_pkg::MSG_DEPTH];
  logic [7:0] msg_addr [scn_pkg::MSG_DEPTH];
  int         msg_cnt;

  status_msg_t pending_status [$];
  int  mismatches = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  int  hold_left = 0;
  int  burst_left = 0;
  bit  burst_stall = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit slot_owned(int i);
    return i >= 0 && i < scn_pkg::NUM_SLOTS && i < tbl_len && slot_taken[i];
  endfunction

  function automatic void grow_table(int s);
    if (tbl_len <= s) tbl_len = s + 1;
  endfunction

  function automatic void record_owner(int s, logic [7:0] node);
    grow_table(s);
    slot_taken[s] = 1'b1;
    slot_node[s] = node;
    slot_age[s] = 0;
  endfunction

  function automatic int first_free_slot();
    int i;
    i = 0;
    while (i < tbl_len && i < scn_pkg::NUM_SLOTS && slot_taken[i]) i++;
    return i;
  endfunction

  function automatic void drop_wanted(int idx);
    for (int i = idx; i + 1 < want_cnt; i++) begin
      want_slot[i] = want_slot[i + 1];
      want_age[i] = want_age[i + 1];
    end
    want_cnt--;
  endfunction

  function automatic void queue_msg(logic [1:0] kind, int s, logic [7:0] addr);
    if (msg_cnt < scn_pkg::MSG_DEPTH) begin
      msg_kind[msg_cnt] = kind;
      msg_slot[msg_cnt] = s;
      msg_addr[msg_cnt] = addr;
      msg_cnt++;
    end
  endfunction

  function automatic void claim_out(int s);
    queue_msg(scn_pkg::KIND_CLAIM, s, 8'd0);
    claim_echoed = 1'b0;
  endfunction

  function automatic void negotiate(logic [2:0] act, logic [7:0] snd, logic [5:0] s,
                                    logic [7:0] addr);
    int top, i, v, n;
    bit lead;
    status_msg_t r;
    msg_cnt = 0;
    case (act)
      scn_pkg::ACT_CLAIM: begin
        if (snd == node_id && !claim_echoed && pend_claim == int'(s)) begin
          top = (want_cnt < scn_pkg::WANT_DEPTH) ? want_cnt : scn_pkg::WANT_DEPTH - 1;
          for (i = top; i > 0; i--) begin
            want_slot[i] = want_slot[i - 1];
            want_age[i] = want_age[i - 1];
          end
          want_slot[0] = s;
          want_age[0] = 0;
          want_cnt = top + 1;
          record_owner(s, snd);
        end
        claim_echoed = 1'b1;
        for (i = 0; i < want_cnt; i++)
          if (want_slot[i] == int'(s) && snd != node_id)
            queue_msg(scn_pkg::KIND_REJ, s, snd);
      end
      scn_pkg::ACT_HB: record_owner(s, snd);
      scn_pkg::ACT_REJ: begin
        record_owner(s, snd);
        if (snd != node_id && addr == node_id) begin
          i = 0;
          while (i < want_cnt) begin
            if (want_slot[i] == int'(s)) drop_wanted(i);
            else i++;
          end
          if (want_cnt == 0) begin
            pend_claim = first_free_slot();
            claim_out(pend_claim);
          end else if (want_cnt == 1) begin
            grow_table(want_slot[0]);
            slot_age[want_slot[0]] = 0;
          end
          if (want_cnt > 0 && want_age[0] < 31) want_age[0]++;
        end
      end
      scn_pkg::ACT_TICK: begin
        for (i = 0; i < tbl_len && i < scn_pkg::NUM_SLOTS; i++) begin
          if (slot_taken[i]) begin
            if (slot_age[i] < 31) slot_age[i]++;
            if (slot_age[i] > expiry) slot_taken[i] = 1'b0;
          end
        end
        if (want_cnt > 0) begin
          for (i = want_cnt - 1; i >= 0; i--) begin
            queue_msg(scn_pkg::KIND_HB, want_slot[i], 8'd0);
            if (i > 0) begin
              if (want_age[i] < 31) want_age[i]++;
              if (want_age[i] > expiry) drop_wanted(i);
            end
          end
          if (want_cnt == 1) begin
            top = want_slot[0] - 1;
            v = top;
            while (v >= 0 && !slot_owned(v)) v--;
            if (v == top || (pend_claim != -1 && pend_claim == v)) pend_claim = -1;
            else pend_claim = v + 1;
            if (pend_claim > -1) claim_out(pend_claim);
          end
        end
      end
      scn_pkg::ACT_START: begin
        pend_claim = first_free_slot();
        claim_out(pend_claim);
      end
      default: ;
    endcase
    n = (msg_cnt > 0) ? msg_cnt : 1;
    lead = slot_owned(0);
    for (i = 0; i < n; i++) begin
      r = '0;
      if (msg_cnt > 0) begin
        r.sv = 1'b1;
        r.kind = msg_kind[i];
        r.slot = 7'(msg_slot[i]);
        r.addr = msg_addr[i];
      end
      r.own = (want_cnt > 0) ? 6'(want_slot[0]) : 6'd0;
      r.lead = lead ? slot_node[0] : 8'd0;
      r.st = want_cnt > 0 && lead;
      r.lst = (i == n - 1);
      pending_status.push_back(r);
    end
  endfunction

  initial begin
    status_msg_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {send_valid_o, send_kind_o, send_slot_o, send_addressee_o, own_slot_o,
               slot0_owner_o, status_valid_o, last_o};
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", got);
        end else begin
          want = pending_status.pop_front();
          if (got.sv !== want.sv || got.kind !== want.kind || got.slot !== want.slot ||
              got.addr !== want.addr || got.own !== want.own || got.lead !== want.lead ||
              got.st !== want.st || got.lst !== want.lst) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else if (!receiver_idles) begin
        out_stall_i <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_stall = $urandom_range(0, 2) == 0;
          burst_left = $urandom_range(1, 14);
        end
        burst_left--;
        out_stall_i <= burst_stall;
      end
    end
  end

  task automatic send_item(logic [2:0] act, logic [7:0] snd, logic [5:0] s, logic [7:0] addr);
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    action_i <= act;
    sender_id_i <= snd;
    slot_i <= s;
    addressee_i <= addr;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    negotiate(act, snd, s, addr);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == scn_pkg::REG_MY_ID) node_id = data;
    else expiry = data[3:0];
  endtask

  function automatic logic [7:0] other_node();
    logic [7:0] n;
    n = 8'($urandom);
    return (n == node_id) ? ~n : n;
  endfunction

  function automatic logic [5:0] some_wanted();
    return (want_cnt > 0) ? 6'(want_slot[$urandom_range(0, want_cnt - 1)])
                          : 6'($urandom_range(0, 63));
  endfunction

  task automatic echo_claim();
    if (pend_claim >= 0 && pend_claim < scn_pkg::NUM_SLOTS)
      send_item(scn_pkg::ACT_CLAIM, node_id, 6'(pend_claim), 8'($urandom));
    else
      send_item(scn_pkg::ACT_HB, other_node(), 6'($urandom_range(0, 63)), 8'd0);
  endtask

  task automatic test_directed();
    write_reg(scn_pkg::REG_MY_ID, 8'hFF);
    write_reg(scn_pkg::REG_TIMEOUT, 8'd15);
    send_item(scn_pkg::ACT_START, 8'h00, 6'd0, 8'h00);
    echo_claim();
    send_item(scn_pkg::ACT_HB, 8'h00, 6'd0, 8'h00);
    send_item(scn_pkg::ACT_HB, 8'hAA, 6'd63, 8'hFF);
    send_item(scn_pkg::ACT_TICK, 8'h00, 6'd0, 8'h00);
    echo_claim();
    send_item(scn_pkg::ACT_CLAIM, 8'h12, some_wanted(), 8'h00);
    send_item(scn_pkg::ACT_CLAIM, 8'hFF, 6'd5, 8'h00);
    send_item(scn_pkg::ACT_REJ, 8'h55, some_wanted(), 8'hFF);
    send_item(scn_pkg::ACT_REJ, 8'h33, 6'd7, 8'h34);
    send_item(scn_pkg::ACT_REJ, 8'hFF, 6'd0, 8'hFF);
    echo_claim();
    send_item(scn_pkg::ACT_REJ, 8'h01, some_wanted(), 8'hFF);
    send_item(3'd5, 8'hFF, 6'd63, 8'hFF);
    send_item(3'd6, 8'h00, 6'd0, 8'h00);
    send_item(3'd7, 8'hA5, 6'd21, 8'h5A);
    write_reg(scn_pkg::REG_TIMEOUT, 8'd1);
    repeat (3) send_item(scn_pkg::ACT_TICK, 8'h00, 6'd0, 8'h00);
    write_reg(scn_pkg::REG_MY_ID, 8'h00);
    send_item(scn_pkg::ACT_START, 8'hFF, 6'd63, 8'hFF);
    echo_claim();
    send_item(scn_pkg::ACT_TICK, 8'hFF, 6'd63, 8'hFF);
  endtask

  task automatic test_pressure();
    write_reg(scn_pkg::REG_TIMEOUT, 8'd10);
    hold_left = 300;
    sender_idles = 1'b0;
    send_item(scn_pkg::ACT_START, 8'h00, 6'd0, 8'h00);
    echo_claim();
    repeat (6) send_item(scn_pkg::ACT_TICK, 8'h00, 6'd0, 8'h00);
    sender_idles = 1'b1;
  endtask

  task automatic test_random(int items);
    for (int j = 0; j < items; j++) begin
      if (j == items / 2) begin
        write_reg(scn_pkg::REG_MY_ID, 8'($urandom));
        write_reg(scn_pkg::REG_TIMEOUT, 8'($urandom_range(1, 15)));
      end
      if (j == items - items / 4) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1: send_item(scn_pkg::ACT_TICK, 8'($urandom), 6'($urandom), 8'($urandom));
        2: send_item(scn_pkg::ACT_START, 8'($urandom), 6'($urandom), 8'($urandom));
        3, 4: echo_claim();
        5: send_item(scn_pkg::ACT_HB, other_node(), 6'($urandom), 8'($urandom));
        6: send_item(scn_pkg::ACT_REJ, other_node(), some_wanted(), node_id);
        7: send_item(scn_pkg::ACT_CLAIM, other_node(), some_wanted(), 8'($urandom));
        8: send_item(3'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
        default: send_item(scn_pkg::ACT_REJ, 8'($urandom), 6'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    node_id = '0;
    expiry = scn_pkg::TIMEOUT_RST;
    for (int i = 0; i < scn_pkg::NUM_SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_node[i] = '0;
      slot_age[i] = 0;
    end
    tbl_len = 0;
    want_cnt = 0;
    pend_claim = -1;
    claim_echoed = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pressure();
    test_random(130);
    drain();
    repeat (200) @(posedge clk_i);
    mismatches += pending_status.size();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
